>>> sv/sorted_priority_queue_macros.svh
// Assertion macros used by the RTL of the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

`ifndef ASSERT_OFF

`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define SPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SPQ_ASSERT(lbl, prop, msg)
`define SPQ_ASSERT_IMP(lbl, ante, cons, msg)
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> sv/spq_pkg.sv
`default_nettype none

package spq_pkg;

  localparam int TAG_W  = 16;
  localparam int PRIO_W = 4;
  localparam int STAT_W = 2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LIST   = 1'b1;

  localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STAT_W-1:0] ST_DROPPED  = 2'd1;
  localparam logic [STAT_W-1:0] ST_ENTRY    = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
  } entry_t;

endpackage

`default_nettype wire

>>> sv/spq_ram.sv
`default_nettype none

module spq_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> sv/sorted_priority_queue.sv
// Inserting to a full or empty store or listing an empty one strobes the result next cycle.
// Insert: entries of higher priority are shifted up one at a time from the tail, as set by the
// single read and single write port of the entry memory, then the new entry fills the gap.
// List: results on consecutive cycles, one per entry, via the RAM read and output registers.
// A new transaction may start in the cycle its predecessor's last result is shown.
// Synchronous reset empties the queue; the entry memory is not cleared; unset words go unused.
`default_nettype none
`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue #(
  parameter int DEPTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        in_cmd,
  input  wire logic [spq_pkg::TAG_W-1:0]   in_customer_tag,
  input  wire logic [spq_pkg::PRIO_W-1:0]  in_priority_req,
  output logic                             out_valid,
  output logic [spq_pkg::STAT_W-1:0]       out_status,
  output logic [spq_pkg::TAG_W-1:0]        out_entry_tag,
  output logic [spq_pkg::PRIO_W-1:0]       out_entry_priority,
  output logic                             out_last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_INS, S_HEAD, S_LIST} state_t;

  state_t                       state_r, state_nxt;
  logic [CW-1:0]                fill_r, fill_nxt;
  logic [AW-1:0]                idx_r, idx_nxt;
  spq_pkg::entry_t              new_r, new_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [spq_pkg::STAT_W-1:0]   out_status_r, out_status_nxt;
  logic [spq_pkg::TAG_W-1:0]    out_tag_r, out_tag_nxt;
  logic [spq_pkg::PRIO_W-1:0]   out_prio_r, out_prio_nxt;
  logic                         out_last_r, out_last_nxt;

  logic                         accept;
  logic                         full;
  logic [AW-1:0]                last_idx;
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [AW-1:0]                ram_raddr;
  spq_pkg::entry_t              ram_wdata;
  spq_pkg::entry_t              ram_rdata;
  spq_pkg::entry_t              in_entry;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign full     = (fill_r == CW'(DEPTH));
  assign last_idx = AW'(fill_r - 1'b1);
  assign in_entry = '{tag: in_customer_tag, prio: in_priority_req};

  spq_ram #(
    .WIDTH ($bits(spq_pkg::entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    idx_nxt        = idx_r;
    new_nxt        = new_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = spq_pkg::ST_INSERTED;
    out_tag_nxt    = '0;
    out_prio_nxt   = '0;
    out_last_nxt   = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = idx_r + 1'b1;
    ram_wdata      = new_r;
    ram_raddr      = idx_r;
    case (state_r)
      S_IDLE: begin
        ram_raddr = (in_cmd == spq_pkg::CMD_LIST) ? '0 : last_idx;
        if (accept) begin
          new_nxt = in_entry;
          if (in_cmd == spq_pkg::CMD_INSERT) begin
            if (full) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = spq_pkg::ST_DROPPED;
              out_last_nxt   = 1'b1;
            end else if (fill_r == '0) begin
              ram_we         = 1'b1;
              ram_waddr      = '0;
              ram_wdata      = in_entry;
              fill_nxt       = fill_r + 1'b1;
              out_valid_nxt  = 1'b1;
              out_status_nxt = spq_pkg::ST_INSERTED;
              out_last_nxt   = 1'b1;
            end else begin
              idx_nxt   = last_idx;
              state_nxt = S_INS;
            end
          end else begin
            if (fill_r == '0) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = spq_pkg::ST_EMPTY;
              out_last_nxt   = 1'b1;
            end else begin
              idx_nxt   = '0;
              state_nxt = S_LIST;
            end
          end
        end
      end
      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r + 1'b1;
        if (ram_rdata.prio > new_r.prio) begin
          ram_wdata = ram_rdata;
          if (idx_r == '0) begin
            state_nxt = S_HEAD;
          end else begin
            idx_nxt   = idx_r - 1'b1;
            ram_raddr = idx_r - 1'b1;
          end
        end else begin
          ram_wdata      = new_r;
          fill_nxt       = fill_r + 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = spq_pkg::ST_INSERTED;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_HEAD: begin
        ram_we         = 1'b1;
        ram_waddr      = '0;
        ram_wdata      = new_r;
        fill_nxt       = fill_r + 1'b1;
        out_valid_nxt  = 1'b1;
        out_status_nxt = spq_pkg::ST_INSERTED;
        out_last_nxt   = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_LIST: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = spq_pkg::ST_ENTRY;
        out_tag_nxt    = ram_rdata.tag;
        out_prio_nxt   = ram_rdata.prio;
        if (CW'(idx_r) + 1'b1 == fill_r) begin
          out_last_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          ram_raddr = idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    new_r        <= new_nxt;
    out_status_r <= out_status_nxt;
    out_tag_r    <= out_tag_nxt;
    out_prio_r   <= out_prio_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_entry_tag      = out_tag_r;
  assign out_entry_priority = out_prio_r;
  assign out_last           = out_last_r;

  `SPQ_ASSERT(a_fill_bound, fill_r <= CW'(DEPTH), "Fill count exceeds the depth.")
  `SPQ_ASSERT_IMP(a_single_last, out_valid_r && out_status_r != spq_pkg::ST_ENTRY, out_last_r, "A non-listing result is not marked last.")
  `SPQ_ASSERT_NEXT(a_accept_progress, accept, busy || out_valid_r, "An accepted transaction neither started work nor gave a result.")
  `SPQ_ASSERT_IMP(a_ins_room, state_r == S_INS || state_r == S_HEAD, fill_r != '0 && !full, "Insert in progress on an empty or full store.")
  `SPQ_ASSERT_IMP(a_insert_grows, out_valid_r && out_status_r == spq_pkg::ST_INSERTED, fill_r == $past(fill_r) + 1'b1, "An insert did not grow the fill count by one.")

endmodule

`default_nettype wire

>>> tb/sv/sorted_priority_queue_tb.sv
`timescale 1ns / 1ps

module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int DEPTH = 16;

  typedef struct {
    logic              cmd;
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
    bit                wait_drain;
  } queue_request_t;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
    logic              last;
  } queue_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              in_cmd = CMD_INSERT;
  logic [TAG_W-1:0]  in_customer_tag = '0;
  logic [PRIO_W-1:0] in_priority_req = '0;
  logic              busy;
  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic [TAG_W-1:0]  out_entry_tag;
  logic [PRIO_W-1:0] out_entry_priority;
  logic              out_last;

  queue_request_t request_backlog[$];
  queue_result_t  due_results[$];
  entry_t         model_store[DEPTH];
  int             model_fill = 0;

  int requests_total = 0;
  int requests_accepted = 0;
  int results_owed = 0;
  int results_seen = 0;
  int mismatch_count = 0;
  int insert_count = 0;
  int drop_count = 0;
  int list_count = 0;
  int empty_list_count = 0;
  int burst_left = 0;
  int gap_left = 0;

  sorted_priority_queue #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_cmd(in_cmd),
    .in_customer_tag(in_customer_tag),
    .in_priority_req(in_priority_req),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_entry_tag(out_entry_tag),
    .out_entry_priority(out_entry_priority),
    .out_last(out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < 25) begin
      $display("ERROR at %0t ns: %s", $time, what);
    end
    mismatch_count++;
  endtask

  task automatic add_request(input logic cmd, input logic [TAG_W-1:0] tag,
                             input logic [PRIO_W-1:0] prio, input bit wait_drain);
    queue_request_t req;
    req.cmd = cmd;
    req.tag = tag;
    req.prio = prio;
    req.wait_drain = wait_drain;
    request_backlog.push_back(req);
    requests_total++;
  endtask

  function automatic queue_result_t make_result(input logic [STAT_W-1:0] status,
                                                input logic [TAG_W-1:0] tag,
                                                input logic [PRIO_W-1:0] prio,
                                                input logic last);
    queue_result_t res;
    res.status = status;
    res.tag = tag;
    res.prio = prio;
    res.last = last;
    return res;
  endfunction

  // Updates the sorted store and queues the results that one transaction must produce.
  function automatic int predict_queue_results(input logic cmd, input logic [TAG_W-1:0] tag,
                                               input logic [PRIO_W-1:0] prio);
    int pos;
    if (cmd == CMD_INSERT) begin
      if (model_fill >= DEPTH) begin
        drop_count++;
        due_results.push_back(make_result(ST_DROPPED, '0, '0, 1'b1));
        return 1;
      end
      pos = 0;
      while (pos < model_fill && model_store[pos].prio <= prio) pos++;
      for (int i = model_fill; i > pos; i--) model_store[i] = model_store[i-1];
      model_store[pos].tag = tag;
      model_store[pos].prio = prio;
      model_fill++;
      insert_count++;
      due_results.push_back(make_result(ST_INSERTED, '0, '0, 1'b1));
      return 1;
    end
    list_count++;
    if (model_fill == 0) begin
      empty_list_count++;
      due_results.push_back(make_result(ST_EMPTY, '0, '0, 1'b1));
      return 1;
    end
    for (int i = 0; i < model_fill; i++) begin
      due_results.push_back(make_result(ST_ENTRY, model_store[i].tag, model_store[i].prio,
                                        (i == model_fill - 1)));
    end
    return model_fill;
  endfunction

  always @(posedge clk) begin
    bit             accepted;
    bit             may_issue;
    queue_request_t req;
    if (rst_n) begin
      accepted = start && !busy;
      if (accepted) begin
        results_owed <= results_owed + predict_queue_results(in_cmd, in_customer_tag,
                                                             in_priority_req);
        requests_accepted <= requests_accepted + 1;
      end
      if (!start || accepted) begin
        may_issue = request_backlog.size() > 0 && gap_left == 0;
        if (may_issue && request_backlog[0].wait_drain) begin
          may_issue = !accepted && results_owed == results_seen;
        end
        if (may_issue) begin
          req = request_backlog.pop_front();
          start <= 1'b1;
          in_cmd <= req.cmd;
          in_customer_tag <= req.tag;
          in_priority_req <= req.prio;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          start <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    queue_result_t want;
    if (rst_n && out_valid) begin
      if (results_seen >= results_owed) begin
        report_mismatch($sformatf("result with status %0d and no expectation waiting",
                                  out_status));
      end else begin
        want = due_results.pop_front();
        if (out_status !== want.status) begin
          report_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
        end
        if (out_entry_tag !== want.tag) begin
          report_mismatch($sformatf("entry tag 0x%h, expected 0x%h", out_entry_tag,
                                    want.tag));
        end
        if (out_entry_priority !== want.prio) begin
          report_mismatch($sformatf("entry priority %0d, expected %0d", out_entry_priority,
                                    want.prio));
        end
        if (out_last !== want.last) begin
          report_mismatch($sformatf("last %b, expected %b", out_last, want.last));
        end
        results_seen <= results_seen + 1;
      end
    end
  end

  initial begin
    #2ms;
    $display("Timeout: the queue stopped answering.");
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    add_request(CMD_LIST, 16'h0000, 4'h0, 1'b0);
    add_request(CMD_INSERT, 16'hFFFF, 4'hF, 1'b0);
    add_request(CMD_INSERT, 16'h0000, 4'h0, 1'b0);
    add_request(CMD_LIST, 16'hFFFF, 4'hF, 1'b0);
    add_request(CMD_INSERT, 16'h1234, 4'hF, 1'b0);
    add_request(CMD_INSERT, 16'h0001, 4'h0, 1'b0);
    add_request(CMD_INSERT, 16'h8000, 4'h7, 1'b0);
    add_request(CMD_INSERT, 16'h7FFF, 4'h8, 1'b0);
    add_request(CMD_LIST, 16'hA5A5, 4'h5, 1'b0);
    add_request(CMD_INSERT, 16'hAAAA, 4'h7, 1'b0);
    add_request(CMD_INSERT, 16'h5555, 4'h0, 1'b0);
    add_request(CMD_LIST, 16'h0000, 4'h0, 1'b0);
    for (int i = 0; i < DEPTH - 10; i++) begin
      add_request(CMD_INSERT, TAG_W'($urandom_range(0, 65535)),
                  PRIO_W'($urandom_range(0, 15)), 1'b0);
    end
    add_request(CMD_LIST, 16'h0000, 4'h0, 1'b0);
    add_request(CMD_INSERT, 16'hFFFF, 4'hF, 1'b0);
    add_request(CMD_INSERT, 16'h0000, 4'h0, 1'b0);
    add_request(CMD_LIST, 16'h0000, 4'h0, 1'b0);
    for (int i = 0; i < 306; i++) begin
      add_request($urandom_range(0, 1) ? CMD_LIST : CMD_INSERT,
                  TAG_W'($urandom_range(0, 65535)), PRIO_W'($urandom_range(0, 15)),
                  (i == 0) || ($urandom_range(0, 49) == 0));
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (requests_accepted != requests_total || results_owed != results_seen);
    repeat (DEPTH + 8) @(posedge clk);

    if (due_results.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", due_results.size()));
    end
    $display("Run covered %0d inserts, %0d drops on a full queue and %0d listings",
             insert_count, drop_count, list_count);
    $display("(%0d on an empty queue), with %0d results checked field by field.",
             empty_list_count, results_seen);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches found.", mismatch_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/spq_pkg.sv
sv/spq_ram.sv
sv/sorted_priority_queue.sv
tb/sv/sorted_priority_queue_tb.sv
